>>> rtl/nspc_pkg.sv
package nspc_pkg;

  localparam int RGB_W    = 24;
  localparam int OUT_IDX_W = 6;
  localparam int STATUS_W = 2;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request and restart the scan
    logic issue;   // read one seed from the table
    logic finish;  // complete the item and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;       // no seeds stored
    logic last_issue;  // the read being issued is the last stored seed
    logic pipe_busy;   // seeds still in flight through the distance pipeline
    logic out_free;    // result register can take a new result this cycle
  } stat_t;

endpackage

>>> rtl/nspc_ctrl.sv
module nspc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           kind,
  output logic           in_stall,
  input  nspc_pkg::stat_t stat,
  output nspc_pkg::cmd_t  cmd
);
  import nspc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (kind == KIND_ADD || stat.empty) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat.last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cmd.load   = 1'b0;
    cmd.issue  = 1'b0;
    cmd.finish = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
      end
      S_DRAIN: begin
      end
      S_FINISH: begin
        cmd.finish = stat.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/nspc_datapath.sv
module nspc_datapath #(
  parameter int MAX_SEEDS  = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  nspc_pkg::cmd_t                      cmd,
  output nspc_pkg::stat_t                     stat,
  input  logic                                kind,
  input  logic [COORD_BITS-1:0]               x_coord,
  input  logic [COORD_BITS-1:0]               y_coord,
  input  logic [nspc_pkg::RGB_W-1:0]          seed_rgb,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [nspc_pkg::STATUS_W-1:0]       status,
  output logic [nspc_pkg::RGB_W-1:0]          pixel_rgb,
  output logic [nspc_pkg::OUT_IDX_W-1:0]      nearest_index
);
  import nspc_pkg::*;

  localparam int IDX_W  = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int CNT_W  = $clog2(MAX_SEEDS + 1);
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = SQ_W + 1;
  localparam int ENT_W  = 2 * COORD_BITS + RGB_W;

  // Request registers.
  logic                  req_kind;
  logic [COORD_BITS-1:0] req_x;
  logic [COORD_BITS-1:0] req_y;
  logic [RGB_W-1:0]      req_rgb;

  logic [CNT_W-1:0] seed_count;
  logic [CNT_W-1:0] scan_ptr;
  logic             full;

  // Seed table: x, y and color of each slot in one word.
  logic [ENT_W-1:0] seed_mem [MAX_SEEDS];

  // Stage 1: registered read.
  logic                  v1;
  logic [IDX_W-1:0]      idx1;
  logic [ENT_W-1:0]      rd_word;

  // Stage 2: squared differences.
  logic                  v2;
  logic [IDX_W-1:0]      idx2;
  logic [RGB_W-1:0]      col2;
  logic [SQ_W-1:0]       sqx;
  logic [SQ_W-1:0]       sqy;

  // Stage 3: running best.
  logic                  best_valid;
  logic [DIST_W-1:0]     best_dist;
  logic [IDX_W-1:0]      best_idx;
  logic [RGB_W-1:0]      best_rgb;

  logic [COORD_BITS-1:0] rx;
  logic [COORD_BITS-1:0] ry;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [DIST_W-1:0]     cand_dist;
  logic                  out_free;
  logic                  do_write;
  logic [IDX_W+OUT_IDX_W-1:0] cnt_ext;
  logic [IDX_W+OUT_IDX_W-1:0] best_ext;

  assign full     = (seed_count == CNT_W'(MAX_SEEDS));
  assign out_free = !out_valid || !out_stall;
  assign do_write = cmd.finish && (req_kind == KIND_ADD) && !full;

  assign stat.empty      = (seed_count == '0);
  assign stat.last_issue = (CNT_W'(scan_ptr + CNT_W'(1)) == seed_count);
  assign stat.pipe_busy  = v1 || v2;
  assign stat.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind <= kind;
      req_x    <= x_coord;
      req_y    <= y_coord;
      req_rgb  <= seed_rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_count <= '0;
    end else if (do_write) begin
      seed_count <= CNT_W'(seed_count + CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_ptr <= '0;
    end else if (cmd.load) begin
      scan_ptr <= '0;
    end else if (cmd.issue) begin
      scan_ptr <= CNT_W'(scan_ptr + CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      seed_mem[seed_count[IDX_W-1:0]] <= {req_x, req_y, req_rgb};
    end
    if (cmd.issue) begin
      rd_word <= seed_mem[scan_ptr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  assign rx = rd_word[ENT_W-1 -: COORD_BITS];
  assign ry = rd_word[RGB_W+COORD_BITS-1 -: COORD_BITS];
  assign dx = (req_x >= rx) ? (req_x - rx) : (rx - req_x);
  assign dy = (req_y >= ry) ? (req_y - ry) : (ry - req_y);

  always_ff @(posedge clk) begin
    idx1 <= scan_ptr[IDX_W-1:0];
    idx2 <= idx1;
    col2 <= rd_word[RGB_W-1:0];
    sqx  <= SQ_W'(dx) * SQ_W'(dx);
    sqy  <= SQ_W'(dy) * SQ_W'(dy);
  end

  assign cand_dist = DIST_W'(sqx) + DIST_W'(sqy);

  // Strict less-than keeps the lower index on equal distances.
  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
    end else if (cmd.load) begin
      best_valid <= 1'b0;
    end else if (v2) begin
      best_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && (!best_valid || cand_dist < best_dist)) begin
      best_dist <= cand_dist;
      best_idx  <= idx2;
      best_rgb  <= col2;
    end
  end

  assign cnt_ext  = {{OUT_IDX_W{1'b0}}, seed_count[IDX_W-1:0]};
  assign best_ext = {{OUT_IDX_W{1'b0}}, best_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (req_kind == KIND_ADD) begin
        pixel_rgb <= '0;
        if (full) begin
          status        <= ST_FULL;
          nearest_index <= '0;
        end else begin
          status        <= ST_OK;
          nearest_index <= cnt_ext[OUT_IDX_W-1:0];
        end
      end else if (seed_count == '0) begin
        status        <= ST_EMPTY;
        pixel_rgb     <= '0;
        nearest_index <= '0;
      end else begin
        status        <= ST_OK;
        pixel_rgb     <= best_rgb;
        nearest_index <= best_ext[OUT_IDX_W-1:0];
      end
    end
  end

endmodule

>>> rtl/nearest_seed_pixel_colorer.sv
// Throughput: one item at a time; the query time is set by the single read port of the
// seed table, which supplies one seed per cycle to the distance pipeline.
// Reset (rst, synchronous) empties the seed table and drops any pending result;
// table contents need no clearing since only written slots are ever read.
module nearest_seed_pixel_colorer #(
  parameter int MAX_SEEDS  = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           kind,
  input  logic [COORD_BITS-1:0]          x_coord,
  input  logic [COORD_BITS-1:0]          y_coord,
  input  logic [nspc_pkg::RGB_W-1:0]     seed_rgb,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [nspc_pkg::STATUS_W-1:0]  status,
  output logic [nspc_pkg::RGB_W-1:0]     pixel_rgb,
  output logic [nspc_pkg::OUT_IDX_W-1:0] nearest_index
);
  import nspc_pkg::*;

  // The controller sequences each item: it takes an input transfer while idle,
  // steps the table scan for queries, waits for the distance pipeline to empty,
  // and then hands the finished result to the output register.
  cmd_t  cmd;
  stat_t stat;

  nspc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the seed table, the three-stage distance pipeline
  // (read, square, compare) and the result register. The result register
  // separates the two sides, so a new input transfer can be taken while an
  // earlier result still waits for its output transfer.
  nspc_datapath #(
    .MAX_SEEDS  (MAX_SEEDS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .kind          (kind),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .seed_rgb      (seed_rgb),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .pixel_rgb     (pixel_rgb),
    .nearest_index (nearest_index)
  );

endmodule
